[sv/srlt_pkg.sv]
// ----------------------------------------------------------------------------
// srlt_pkg: shared types and constants for the sector range lock table
// Defines the operation codes, the field widths, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srlt_pkg;

	localparam int SECTOR_W = 32;
	localparam int COUNT_W  = 16;
	localparam int END_W    = SECTOR_W + 1;

	localparam logic OP_LOCK   = 1'b0;
	localparam logic OP_UNLOCK = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture the request, restart the scan
		logic scan;    // advance the slot scan
		logic commit;  // update the table and load the answer
	} srlt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;  // every slot has been compared
	} srlt_sts_t;

endpackage

[sv/srlt_ctrl.sv]
// ----------------------------------------------------------------------------
// srlt_ctrl: sequencing for the sector range lock table
// Accepts one transaction, runs the slot scan, commits the outcome and
// drives the output valid register.
// ----------------------------------------------------------------------------
module srlt_ctrl
	import srlt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output srlt_cmd_t cmd,
	input  srlt_sts_t sts
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// hold until the answer register can take the result
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/srlt_dp.sv]
// ----------------------------------------------------------------------------
// srlt_dp: slot table and scan datapath for the sector range lock table
// Holds the slot memory and used bits, compares one slot per cycle against
// the captured request and applies the lock or unlock at commit.
// ----------------------------------------------------------------------------
module srlt_dp
	import srlt_pkg::*;
#(
	parameter int SLOT_COUNT = 8
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  srlt_cmd_t           cmd,
	output srlt_sts_t           sts,
	input  logic                op,
	input  logic [SECTOR_W-1:0] start_sector,
	input  logic [COUNT_W-1:0]  sector_count,
	input  logic                read_only,
	output logic                granted
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = SECTOR_W + COUNT_W + 1;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT);

	// slot memory entry: {shared, length, start}
	logic [ENT_W-1:0]      mem [SLOT_COUNT];
	logic [ENT_W-1:0]      rd_data_q;
	logic [SLOT_COUNT-1:0] used_q;

	logic                  req_op_q;
	logic [SECTOR_W-1:0]   req_start_q;
	logic [COUNT_W-1:0]    req_count_q;
	logic                  req_shared_q;
	logic [END_W-1:0]      req_end_q;

	logic [CNT_W-1:0]      addr_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic                  cmp_vld_q;
	logic                  conflict_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  hit_found_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic                  granted_q;

	logic [SECTOR_W-1:0]   slot_start;
	logic [COUNT_W-1:0]    slot_len;
	logic                  slot_shared;
	logic [END_W-1:0]      slot_end;
	logic                  slot_used;
	logic                  overlap;
	logic                  exact;
	logic                  lock_ok;
	logic                  do_issue;

	assign slot_start  = rd_data_q[SECTOR_W-1:0];
	assign slot_len    = rd_data_q[SECTOR_W +: COUNT_W];
	assign slot_shared = rd_data_q[ENT_W-1];
	assign slot_end    = {1'b0, slot_start} + {{(END_W-COUNT_W){1'b0}}, slot_len};
	assign slot_used   = used_q[cmp_idx_q];
	assign overlap     = ({1'b0, slot_start} < req_end_q) && ({1'b0, req_start_q} < slot_end);
	assign exact       = (slot_start == req_start_q) && (slot_len == req_count_q);
	assign lock_ok     = !conflict_q && free_found_q;
	assign do_issue    = cmd.scan && (addr_q != LAST_CNT);

	assign sts.scan_done = (addr_q == LAST_CNT) && !cmp_vld_q;
	assign granted       = granted_q;

	// slot memory: one registered read, one write at commit
	always_ff @(posedge clk) begin
		if (do_issue) begin
			rd_data_q <= mem[addr_q[IDX_W-1:0]];
		end
		if (cmd.commit && req_op_q == OP_LOCK && lock_ok) begin
			mem[free_idx_q] <= {req_shared_q, req_count_q, req_start_q};
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_op_q     <= op;
			req_start_q  <= start_sector;
			req_count_q  <= sector_count;
			req_shared_q <= read_only;
			req_end_q    <= {1'b0, start_sector} + {{(END_W-COUNT_W){1'b0}}, sector_count};
		end
	end

	// scan pointer and compare results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			addr_q       <= '0;
			cmp_idx_q    <= '0;
			cmp_vld_q    <= 1'b0;
			conflict_q   <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			granted_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q       <= '0;
				cmp_vld_q    <= 1'b0;
				conflict_q   <= 1'b0;
				free_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
			end else if (cmd.scan) begin
				cmp_vld_q <= do_issue;
				if (do_issue) begin
					cmp_idx_q <= addr_q[IDX_W-1:0];
					addr_q    <= addr_q + CNT_W'(1);
				end
				if (cmp_vld_q) begin
					if (slot_used) begin
						if (overlap && !(req_shared_q && slot_shared)) begin
							conflict_q <= 1'b1;
						end
						if (exact && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= cmp_idx_q;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_idx_q;
					end
				end
			end
			if (cmd.commit) begin
				if (req_op_q == OP_LOCK) begin
					granted_q <= lock_ok;
					if (lock_ok) begin
						used_q[free_idx_q] <= 1'b1;
					end
				end else begin
					granted_q <= 1'b1;
					if (hit_found_q) begin
						used_q[hit_idx_q] <= 1'b0;
					end
				end
			end
		end
	end

endmodule

[sv/sector_range_lock_table_top.sv]
// ----------------------------------------------------------------------------
// sector_range_lock_table_top: reader/writer lock table over sector ranges
// Grants or refuses lock requests against a table of held ranges and frees
// held ranges on unlock, one transaction at a time.
// ----------------------------------------------------------------------------
// Each input transaction is a lock (op = 0) or an unlock (op = 1) of the
// range [start_sector, start_sector + sector_count), ends taken 33 bits wide
// so they never wrap. A lock is granted when a slot is free and the range
// overlaps no held range, unless both sides are read_only; the lowest free
// slot then takes it. A zero-length range overlaps another only when its
// start lies strictly inside the other, but it still occupies a slot. An
// unlock frees the lowest held slot with the same start and count and
// always answers granted = 1; read_only is ignored on unlock. Every
// transaction yields exactly one result. A transaction passes through
// capture, then the scan, which reads one slot per cycle from the slot
// memory, compares it the cycle after the read and then confirms the last
// compare, and then the commit. in_stall is high from the scan through the
// commit and stays high while the commit holds. The result is offered the
// cycle after the commit. The result sits in an output register, so a new
// transaction is taken while an earlier result still waits on out_stall;
// the commit of that new transaction holds until the register is free.
// After reset every slot is free, with no clearing pass.
// ----------------------------------------------------------------------------
module sector_range_lock_table_top
	import srlt_pkg::*;
#(
	parameter int SLOT_COUNT = 8
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [SECTOR_W-1:0] start_sector,
	input  logic [COUNT_W-1:0]  sector_count,
	input  logic                read_only,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                granted
);

	srlt_cmd_t cmd;
	srlt_sts_t sts;

	// sequencing: accept, scan, commit
	srlt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// slot table, comparators and answer register
	srlt_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.start_sector (start_sector),
		.sector_count (sector_count),
		.read_only    (read_only),
		.granted      (granted)
	);

endmodule

[sv/srlt_checker.sv]
// ----------------------------------------------------------------------------
// srlt_checker: port-level checks for the sector range lock table
// Watches the top-level ports over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module srlt_checker
	import srlt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                op,
	input logic [SECTOR_W-1:0] start_sector,
	input logic [COUNT_W-1:0]  sector_count,
	input logic                read_only,
	input logic                out_valid,
	input logic                out_stall,
	input logic                granted
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted))
		else $error("result changed while stalled");

	// a stalled transaction holds its payload until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(op) && $stable(start_sector)
			&& $stable(sector_count) && $stable(read_only))
		else $error("input changed while stalled");

	// the block goes busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// a new result only appears after a transaction was in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a transaction in flight");

	// the busy span of a transaction never lasts one cycle
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |=> in_stall)
		else $error("busy span too short");

endmodule

bind sector_range_lock_table_top srlt_checker u_srlt_checker (.*);

[tb/sv/range_lock_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_lock_checker: grant prediction and result comparison
// Watches both channels of the sector range lock table, predicts the grant
// of every accepted transaction from its own copy of the slot table, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module range_lock_checker
	import srlt_pkg::*;
#(
	parameter int SLOTS = 8
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                op,
	input  logic [SECTOR_W-1:0] start_sector,
	input  logic [COUNT_W-1:0]  sector_count,
	input  logic                read_only,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                granted,
	output int                  mismatch_count,
	output int                  pending_grants
);

	logic                held_used   [SLOTS];
	logic [SECTOR_W-1:0] held_start  [SLOTS];
	logic [COUNT_W-1:0]  held_len    [SLOTS];
	logic                held_shared [SLOTS];

	logic expected_grants [$];
	logic want;

	initial begin
		mismatch_count = 0;
		pending_grants = 0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic void clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			held_used[i]   = 1'b0;
			held_start[i]  = '0;
			held_len[i]    = '0;
			held_shared[i] = 1'b0;
		end
	endfunction

	// Apply one transaction to the table and return the grant it earns.
	function automatic logic predict_grant(input logic kind,
	                                       input logic [SECTOR_W-1:0] first,
	                                       input logic [COUNT_W-1:0] len,
	                                       input logic shared);
		int               free_idx;
		logic             clash;
		logic             freed;
		logic [END_W-1:0] req_end;
		logic [END_W-1:0] held_end;
		if (kind == OP_UNLOCK) begin
			freed = 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!freed && held_used[i] && held_start[i] == first && held_len[i] == len) begin
					held_used[i]   = 1'b0;
					held_start[i]  = '0;
					held_len[i]    = '0;
					held_shared[i] = 1'b0;
					freed          = 1'b1;
				end
			end
			return 1'b1;
		end
		free_idx = -1;
		clash    = 1'b0;
		req_end  = {1'b0, first} + END_W'(len);
		for (int i = 0; i < SLOTS; i++) begin
			if (!held_used[i]) begin
				if (free_idx < 0)
					free_idx = i;
			end else begin
				held_end = {1'b0, held_start[i]} + END_W'(held_len[i]);
				// readers may share a range, anything else collides
				if (END_W'(first) < held_end && END_W'(held_start[i]) < req_end
				    && !(shared && held_shared[i]))
					clash = 1'b1;
			end
		end
		if (clash || free_idx < 0)
			return 1'b0;
		held_used[free_idx]   = 1'b1;
		held_start[free_idx]  = first;
		held_len[free_idx]    = len;
		held_shared[free_idx] = shared;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_table();
			expected_grants.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_grants.push_back(predict_grant(op, start_sector, sector_count, read_only));
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0) begin
					report_mismatch($sformatf("granted %b with no transaction waiting", granted));
				end else begin
					want = expected_grants.pop_front();
					if (granted !== want)
						report_mismatch($sformatf("granted %b, expected %b", granted, want));
				end
			end
		end
		pending_grants <= expected_grants.size();
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: sector range lock table verification top
// Drives lock and unlock transactions into the table under changing idle
// patterns, holds off the result side to fill the block, and reports the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module testbench
	import srlt_pkg::*;
;

	localparam int SLOTS          = 8;
	localparam int RANDOM_PER_RUN = 542;     // per idle phase, three phases
	localparam int HISTORY_DEPTH  = 16;
	localparam int HOLD_OFF       = 300;     // long receiver stall, in cycles
	localparam int DRAIN_CYCLES   = 40;      // settling time after the last result, in cycles
	localparam int CYCLE_LIMIT    = 400000;

	typedef struct packed {
		logic [SECTOR_W-1:0] first;
		logic [COUNT_W-1:0]  len;
	} sector_range_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                op           = OP_LOCK;
	logic [SECTOR_W-1:0] start_sector = '0;
	logic [COUNT_W-1:0]  sector_count = '0;
	logic                read_only    = 1'b0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                granted;

	int mismatch_count;
	int pending_grants;
	int send_idle_pct = 8;
	int recv_idle_pct = 46;
	int cycle_count   = 0;
	int hold_cycles_left = 0;
	bit hold_request  = 1'b0;

	// ranges recently asked for, so that unlocks mostly hit held slots
	sector_range_t recent_ranges [$];

	sector_range_lock_table_top #(
		.SLOT_COUNT(SLOTS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.start_sector (start_sector),
		.sector_count (sector_count),
		.read_only    (read_only),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted)
	);

	range_lock_checker #(
		.SLOTS(SLOTS)
	) grant_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.start_sector   (start_sector),
		.sector_count   (sector_count),
		.read_only      (read_only),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.mismatch_count (mismatch_count),
		.pending_grants (pending_grants)
	);

	always #5 clk = ~clk;

	// Offer one transaction and hold it until the block takes it. Idle cycles
	// go in front of the transaction; valid stays high across back-to-back
	// transactions. Handshake values read right after the edge are the ones
	// the block saw at that edge.
	task automatic offer_request(input logic kind, input logic [SECTOR_W-1:0] first,
	                             input logic [COUNT_W-1:0] len, input logic shared);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		start_sector <= first;
		sector_count <= len;
		read_only    <= shared;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Build a random transaction. Most ranges land in a narrow window so that
	// overlaps, shared locks and a full table come up often; some sit at the
	// top of the sector space or anywhere at all, and some counts are huge.
	task automatic offer_random_request();
		sector_range_t rng;
		logic          kind;
		logic          shared;
		int            pick;
		kind   = ($urandom_range(0, 99) < 45) ? OP_UNLOCK : OP_LOCK;
		shared = 1'($urandom_range(0, 1));
		if (kind == OP_UNLOCK && recent_ranges.size() > 0 && $urandom_range(0, 99) < 80) begin
			rng = recent_ranges[$urandom_range(0, recent_ranges.size() - 1)];
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				rng.first = $urandom_range(0, 255);
			else if (pick < 85)
				rng.first = 32'hFFFF_FF00 | $urandom_range(0, 255);
			else
				rng.first = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				rng.len = '0;
			else if (pick < 75)
				rng.len = COUNT_W'($urandom_range(1, 40));
			else
				rng.len = COUNT_W'($urandom_range(0, 16'hFFFF));
			if (kind == OP_LOCK) begin
				recent_ranges.push_back(rng);
				if (recent_ranges.size() > HISTORY_DEPTH)
					void'(recent_ranges.pop_front());
			end
		end
		offer_request(kind, rng.first, rng.len, shared);
	endtask

	// Result side: random stalls, plus one long hold-off on request. The
	// hold-off lets the output register fill and the next transaction park at
	// its commit, so in_stall stays high while the sender keeps offering.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles_left > 0) begin
				hold_cycles_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request     = 1'b0;
				hold_cycles_left = HOLD_OFF;
				out_stall        <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run if the drain never completes.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk through the table; hold off the receiver right away
		// so the first transactions back up behind the output register.
		hold_request = 1'b1;
		// zero-length lock still takes a slot
		offer_request(OP_LOCK, 32'd0, 16'd0, 1'b0);
		// top of the sector space: the end is 33 bits wide and does not wrap
		offer_request(OP_LOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		// ends exactly where the previous range starts: no overlap
		offer_request(OP_LOCK, 32'hFFFF_0000, 16'hFFFF, 1'b0);
		// readers share overlapping ranges, a writer is refused
		offer_request(OP_LOCK, 32'd100, 16'd10, 1'b1);
		offer_request(OP_LOCK, 32'd105, 16'd10, 1'b1);
		offer_request(OP_LOCK, 32'd109, 16'd1, 1'b0);
		offer_request(OP_LOCK, 32'd114, 16'd1, 1'b1);
		// zero length strictly inside a held range still overlaps it, so a writer is refused
		offer_request(OP_LOCK, 32'd110, 16'd0, 1'b0);
		// fill the last two slots; the table is then full
		offer_request(OP_LOCK, 32'd200, 16'd5, 1'b0);
		offer_request(OP_LOCK, 32'd900, 16'd1, 1'b0);
		// unlock with no match, then with a near miss on the length
		offer_request(OP_UNLOCK, 32'd5000, 16'd3, 1'b0);
		offer_request(OP_UNLOCK, 32'd100, 16'd9, 1'b0);
		// read_only is ignored on unlock
		offer_request(OP_UNLOCK, 32'd100, 16'd10, 1'b0);
		// duplicate shared range: unlock frees the lowest copy only
		offer_request(OP_LOCK, 32'd105, 16'd10, 1'b1);
		offer_request(OP_UNLOCK, 32'd105, 16'd10, 1'b1);
		// wide shared lock blocked by writers, still refused after one of them leaves
		offer_request(OP_LOCK, 32'd0, 16'hFFFF, 1'b1);
		offer_request(OP_UNLOCK, 32'd200, 16'd5, 1'b0);
		offer_request(OP_LOCK, 32'd0, 16'hFFFF, 1'b1);
		// release the held ranges, all but the one at 900
		offer_request(OP_UNLOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		offer_request(OP_UNLOCK, 32'd0, 16'd0, 1'b0);
		offer_request(OP_UNLOCK, 32'hFFFF_0000, 16'hFFFF, 1'b0);
		offer_request(OP_UNLOCK, 32'd105, 16'd10, 1'b0);
		offer_request(OP_UNLOCK, 32'd114, 16'd1, 1'b0);
		offer_request(OP_UNLOCK, 32'd110, 16'd0, 1'b0);
		offer_request(OP_UNLOCK, 32'd0, 16'hFFFF, 1'b1);

		// Random traffic in three idle phases: sender mostly busy with a
		// choppy receiver, then the reverse, then both running flat out.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_RUN; n++)
				offer_random_request();
		end

		// Drop valid, let the checker log the last transaction,
		// then wait for every result and let the block settle.
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_grants == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
